/* rtl/core/bfcp_pkg.sv */
// Package with shared constants, types and the CRC helpers of the frame checker.
package bfcp_pkg;

    localparam int FRAME_W  = 32;
    localparam int POS_W    = 12;
    localparam int CRC_W    = 6;
    localparam int CRC_IN_W = 14;
    localparam int COUNT_W  = 6;
    localparam int OUT_W    = 16;

    localparam logic [4:0]         START_CODE = 5'b11010;
    localparam logic [CRC_W:0]     CRC_POLY   = 7'b1000011;
    localparam logic [COUNT_W-1:0] DEAD_LIMIT = 6'd50;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 6'd52;

    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_BAD_START    = 3'd1,
        STATUS_NW_MISSING   = 3'd2,
        STATUS_TRAILING_SET = 3'd3,
        STATUS_CRC_MISMATCH = 3'd4
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [POS_W-1:0]  raw_pos;
    } check_t;

    typedef logic [CRC_IN_W-1:0][CRC_W-1:0] crc_cols_t;

    // Plain long-division remainder; only evaluated at elaboration.
    function automatic logic [CRC_W-1:0] crc6_raw(input logic [CRC_IN_W-1:0] data);
        logic [CRC_IN_W+CRC_W-1:0] rem;
        rem = {data, {CRC_W{1'b0}}};
        for (int p = CRC_IN_W + CRC_W - 1; p >= CRC_W; p--) begin
            if (rem[p]) begin
                rem = rem ^ ({{(CRC_IN_W-1){1'b0}}, CRC_POLY} << (p - CRC_W));
            end
        end
        return rem[CRC_W-1:0];
    endfunction

    // The CRC is linear, so each data bit contributes a fixed remainder.
    function automatic crc_cols_t crc6_columns();
        crc_cols_t cols;
        for (int i = 0; i < CRC_IN_W; i++) begin
            cols[i] = crc6_raw(CRC_IN_W'(1) << i);
        end
        return cols;
    endfunction

    localparam crc_cols_t CRC_COLS = crc6_columns();

endpackage

/* rtl/core/bfcp_frame_check.sv */
// Frame decoder: start code, nW, trailing bits and CRC6 checks in priority order.
module bfcp_frame_check (
    input  logic [bfcp_pkg::FRAME_W-1:0] frame_word,
    output bfcp_pkg::check_t             check
);
    import bfcp_pkg::*;

    logic [CRC_IN_W-1:0] crc_data;
    logic [CRC_W-1:0]    crc_rem;
    logic [CRC_W-1:0]    crc_expected;

    assign crc_data = frame_word[26:13];

    // XOR of the per-bit remainders; every term is independent.
    always_comb
    begin
        crc_rem = '0;
        for (int i = 0; i < CRC_IN_W; i++) begin
            if (crc_data[i]) begin
                crc_rem = crc_rem ^ CRC_COLS[i];
            end
        end
    end

    assign crc_expected = ~crc_rem;

    always_comb
    begin
        check.raw_pos = frame_word[26:15];
        priority if (frame_word[31:27] != START_CODE) begin
            check.status = STATUS_BAD_START;
        end
        else if (!frame_word[13]) begin
            check.status = STATUS_NW_MISSING;
        end
        else if (frame_word[5:0] != '0) begin
            check.status = STATUS_TRAILING_SET;
        end
        else if (frame_word[12:7] != crc_expected) begin
            check.status = STATUS_CRC_MISMATCH;
        end
        else begin
            check.status = STATUS_OK;
        end
    end

endmodule

/* rtl/core/bfcp_health.sv */
// Sensor health counter: up by two on errors (saturating above the limit), down by one on good frames.
module bfcp_health (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          update,
    input  logic                          is_error,
    output logic                          dead_next,
    output logic [bfcp_pkg::COUNT_W-1:0]  count
);
    import bfcp_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (is_error) begin
            if (count_reg <= DEAD_LIMIT) begin
                count_next = count_reg + COUNT_W'(2);
            end
        end
        else if (count_reg != '0) begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end
        else if (update) begin
            count_reg <= count_next;
        end
    end

    assign dead_next = (count_next > DEAD_LIMIT);
    assign count     = count_reg;

endmodule

/* rtl/core/biss_frame_check_position_unit.sv */
// Top level of the BiSS-style frame checker with position offset and health flag.
//
// Each 32-bit frame word taken on the slave stream yields exactly one result word
// on the master stream, in order. A frame word is first captured in an input
// register; the decoder then checks the start code, the nW bit, the trailing
// zero bits and the inverted CRC6, and once the output register is free or being
// drained the result (position, status, dead flag) is written into it while the
// stored position and the health counter are updated. One word is taken every
// clock cycle as long as the master side keeps up.
// The position offset is written through cfg_we/cfg_wdata and should only change
// while no word is in flight.
module biss_frame_check_position_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration: position offset, applied modulo 4096.
    input  logic                           cfg_we,
    input  logic [bfcp_pkg::POS_W-1:0]     cfg_wdata,
    // Slave stream. tdata: frame_word[31:0].
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bfcp_pkg::FRAME_W-1:0]   s_axis_tdata,
    // Master stream. tdata: position[11:0], status[14:12], sensor_dead[15].
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bfcp_pkg::OUT_W-1:0]     m_axis_tdata
);
    import bfcp_pkg::*;

    logic [POS_W-1:0]   offset_reg;
    logic               in_valid_reg;
    logic [FRAME_W-1:0] in_frame_reg;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic [POS_W-1:0]   last_pos_reg;
    logic [POS_W-1:0]   last_pos_next;

    check_t             check;
    logic               advance;
    logic               is_error;
    logic               dead_next;
    logic [COUNT_W-1:0] err_count;

    // The check stage moves whenever the output register is free or being drained.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            offset_reg <= '0;
        end
        else if (cfg_we) begin
            offset_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_frame_reg <= s_axis_tdata;
        end
    end

    bfcp_frame_check u_check (
        .frame_word (in_frame_reg),
        .check      (check)
    );

    assign is_error = (check.status != STATUS_OK);

    bfcp_health u_health (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (advance),
        .is_error  (is_error),
        .dead_next (dead_next),
        .count     (err_count)
    );

    // A good frame refreshes the stored position; a bad frame repeats it.
    assign last_pos_next = is_error ? last_pos_reg : (check.raw_pos + offset_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_pos_reg <= '0;
        end
        else if (advance) begin
            last_pos_reg <= last_pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_data_reg <= {dead_next, check.status, last_pos_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // The health counter saturates just above the dead limit.
    assert property (@(posedge clk) disable iff (!rst_n) err_count <= COUNT_MAX)
        else $error("health counter passed its ceiling");

    // A rejected frame must leave the stored position untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_error |=> $stable(last_pos_reg))
        else $error("stored position changed on a bad frame");

    // Input back-pressure only when both registers are occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without a full pipeline");

endmodule
